// ===== design/lgc_pkg.sv =====
// Package for the line gradient color block: shared constants and types.
`timescale 1ns / 1ps

package lgc_pkg;

  // Parameter defaults
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  // Fixed field widths
  localparam int CHAN_BITS  = 8;
  localparam int NUM_CHAN   = 3;
  localparam int COLOR_BITS = CHAN_BITS * NUM_CHAN;
  localparam int SPAN_BITS  = 16;

  // End points of the color ramp
  typedef struct packed {
    logic [COLOR_BITS-1:0] start_color;
    logic [COLOR_BITS-1:0] end_color;
  } lgc_colors_t;

  // Side data that travels with a transaction through the divider row
  typedef struct packed {
    logic        one;     // fraction is forced to exactly one
    lgc_colors_t colors;
  } lgc_side_t;

endpackage

// ===== design/lgc_if.sv =====
// Valid/ready channel interfaces for the line gradient color block.
`timescale 1ns / 1ps

interface lgc_item_if #(
  parameter int COORD_BITS = 16
);
  logic                            valid;
  logic                            ready;
  logic signed [COORD_BITS-1:0]    start_x;
  logic signed [COORD_BITS-1:0]    start_y;
  logic signed [COORD_BITS-1:0]    end_x;
  logic signed [COORD_BITS-1:0]    end_y;
  logic signed [COORD_BITS-1:0]    cur_x;
  logic signed [COORD_BITS-1:0]    cur_y;
  logic        [lgc_pkg::COLOR_BITS-1:0] start_color;
  logic        [lgc_pkg::COLOR_BITS-1:0] end_color;
  logic        [lgc_pkg::COLOR_BITS-1:0] cur_color;
  logic        [lgc_pkg::SPAN_BITS-1:0]  span_x;
  logic        [lgc_pkg::SPAN_BITS-1:0]  span_y;

  modport source (
    output valid, start_x, start_y, end_x, end_y, cur_x, cur_y,
           start_color, end_color, cur_color, span_x, span_y,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, end_x, end_y, cur_x, cur_y,
           start_color, end_color, cur_color, span_x, span_y,
    output ready
  );
endinterface

interface lgc_result_if;
  logic                            valid;
  logic                            ready;
  logic [lgc_pkg::COLOR_BITS-1:0]  pixel_color;

  modport source (output valid, pixel_color, input ready);
  modport sink   (input valid, pixel_color, output ready);
endinterface

// ===== design/lgc_front.sv =====
// Front end: axis select, differences, magnitudes and special-case flags.
`timescale 1ns / 1ps

module lgc_front import lgc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  lgc_item_if.sink              item,
  output logic                  v_out,
  input  logic                  rdy_in,
  output logic [COORD_BITS-1:0] rem_out,
  output logic [COORD_BITS-1:0] den_out,
  output lgc_side_t             side_out
);

  localparam int DW = COORD_BITS + 1;

  // Stage 1 registers: signed differences on the major axis
  logic              s1_v;
  logic [DW-1:0]     s1_num;
  logic [DW-1:0]     s1_den;
  logic              s1_pass;
  lgc_colors_t       s1_colors;

  logic              s1_rdy;
  logic              s2_rdy;
  logic              sel_x;
  logic [COORD_BITS-1:0] c_s, c_e, c_c;
  logic [DW-1:0]     num_next, den_next;

  // Stage 2 combinational terms
  logic              n_neg, d_neg;
  logic [DW-1:0]     an_full, ad_full;
  logic [COORD_BITS-1:0] an, ad;
  logic              zero_f, one_f;
  logic [COORD_BITS-1:0] rem_next;

  assign s2_rdy     = !v_out || rdy_in;
  assign s1_rdy     = !s1_v || s2_rdy;
  assign item.ready = s1_rdy;

  // Major axis: x only when its span is strictly larger
  always_comb begin
    sel_x    = item.span_x > item.span_y;
    c_s      = sel_x ? item.start_x : item.start_y;
    c_e      = sel_x ? item.end_x   : item.end_y;
    c_c      = sel_x ? item.cur_x   : item.cur_y;
    num_next = {c_c[COORD_BITS-1], c_c} - {c_s[COORD_BITS-1], c_s};
    den_next = {c_e[COORD_BITS-1], c_e} - {c_s[COORD_BITS-1], c_s};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (s1_rdy) begin
      s1_v <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_num                <= num_next;
      s1_den                <= den_next;
      s1_pass               <= item.cur_color == item.end_color;
      s1_colors.start_color <= item.start_color;
      s1_colors.end_color   <= item.end_color;
    end
  end

  // Magnitudes and clamp classification
  always_comb begin
    n_neg    = s1_num[DW-1];
    d_neg    = s1_den[DW-1];
    an_full  = n_neg ? (~s1_num + DW'(1)) : s1_num;
    ad_full  = d_neg ? (~s1_den + DW'(1)) : s1_den;
    an       = an_full[COORD_BITS-1:0];
    ad       = ad_full[COORD_BITS-1:0];
    zero_f   = (s1_num == '0) || (n_neg != d_neg);
    one_f    = s1_pass || (s1_den == '0) || (!zero_f && (an >= ad));
    rem_next = zero_f ? '0 : an;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (s2_rdy) begin
      v_out <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy) begin
      rem_out         <= rem_next;
      den_out         <= ad;
      side_out.one    <= one_f;
      side_out.colors <= s1_colors;
    end
  end

endmodule

// ===== design/lgc_div_cell.sv =====
// One restoring-division cell: produces one quotient bit per transaction.
`timescale 1ns / 1ps

module lgc_div_cell import lgc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  v_in,
  output logic                  rdy_out,
  input  logic [COORD_BITS-1:0] rem_in,
  input  logic [COORD_BITS-1:0] den_in,
  input  logic [FRAC_BITS-1:0]  quo_in,
  input  lgc_side_t             side_in,
  output logic                  v_out,
  input  logic                  rdy_in,
  output logic [COORD_BITS-1:0] rem_out,
  output logic [COORD_BITS-1:0] den_out,
  output logic [FRAC_BITS-1:0]  quo_out,
  output lgc_side_t             side_out
);

  logic [COORD_BITS:0]   rem_sh;
  logic [COORD_BITS:0]   rem_sub;
  logic                  q_bit;
  logic [COORD_BITS-1:0] rem_next;

  assign rdy_out = !v_out || rdy_in;

  // Shift in a zero, subtract the divisor when it fits
  always_comb begin
    rem_sh   = {rem_in, 1'b0};
    rem_sub  = rem_sh - {1'b0, den_in};
    q_bit    = rem_sh >= {1'b0, den_in};
    rem_next = q_bit ? rem_sub[COORD_BITS-1:0] : rem_sh[COORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (rdy_out) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      rem_out  <= rem_next;
      den_out  <= den_in;
      quo_out  <= {quo_in[FRAC_BITS-2:0], q_bit};
      side_out <= side_in;
    end
  end

endmodule

// ===== design/lgc_blend.sv =====
// Color blend: per-channel weighted mix of start and end colors.
`timescale 1ns / 1ps

module lgc_blend import lgc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 v_in,
  output logic                 rdy_out,
  input  logic [FRAC_BITS-1:0] quo_in,
  input  lgc_side_t            side_in,
  lgc_result_if.source         result
);

  localparam int FW = FRAC_BITS + 1;
  localparam int SW = FRAC_BITS + CHAN_BITS + 1;
  localparam logic [FW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [FW-1:0]         f;
  logic [FW-1:0]         wa;
  logic [SW-1:0]         sum;
  logic [COLOR_BITS-1:0] pixel_next;

  assign rdy_out = !result.valid || result.ready;

  // a*(1-f) + b*f per channel, truncated
  always_comb begin
    f          = side_in.one ? ONE : {1'b0, quo_in};
    wa         = ONE - f;
    sum        = '0;
    pixel_next = '0;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      sum = SW'(side_in.colors.start_color[ch*CHAN_BITS +: CHAN_BITS]) * SW'(wa)
          + SW'(side_in.colors.end_color[ch*CHAN_BITS +: CHAN_BITS]) * SW'(f);
      pixel_next[ch*CHAN_BITS +: CHAN_BITS] = sum[FRAC_BITS +: CHAN_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (rdy_out) begin
      result.valid <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      result.pixel_color <= pixel_next;
    end
  end

endmodule

// ===== design/line_gradient_color.sv =====
// Top level of the line gradient color block: front end, divider row, blend.
//
//   channel  | dir | payload
//   ---------+-----+------------------------------------------------------
//   item     | in  | start/end/cur x,y, start/end/cur color, span_x/span_y
//   result   | out | pixel_color (RGB888)
//
// One transaction per clock sustained while result accepts. The stages are
// two front-end stages, one cell per fraction bit in the divider row, and
// the blend register. Synchronous reset empties every stage. Each stage holds
// its contents only while the stage after it is full and stalled, so bubbles
// close up under backpressure on result.
`timescale 1ns / 1ps

module line_gradient_color import lgc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  lgc_item_if.sink     item,
  lgc_result_if.source result
);

  localparam int NC = FRAC_BITS;

  // Row links: index k feeds cell k, index NC feeds the blend stage
  logic [NC:0]           cv;
  logic [NC:0]           cr;
  logic [COORD_BITS-1:0] rem_a  [NC+1];
  logic [COORD_BITS-1:0] den_a  [NC+1];
  logic [FRAC_BITS-1:0]  quo_a  [NC+1];
  lgc_side_t             side_a [NC+1];

  assign quo_a[0] = '0;

  lgc_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .v_out    (cv[0]),
    .rdy_in   (cr[0]),
    .rem_out  (rem_a[0]),
    .den_out  (den_a[0]),
    .side_out (side_a[0])
  );

  // Divider row, one quotient bit per cell
  for (genvar k = 0; k < NC; k++) begin : g_cell
    lgc_div_cell #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .v_in     (cv[k]),
      .rdy_out  (cr[k]),
      .rem_in   (rem_a[k]),
      .den_in   (den_a[k]),
      .quo_in   (quo_a[k]),
      .side_in  (side_a[k]),
      .v_out    (cv[k+1]),
      .rdy_in   (cr[k+1]),
      .rem_out  (rem_a[k+1]),
      .den_out  (den_a[k+1]),
      .quo_out  (quo_a[k+1]),
      .side_out (side_a[k+1])
    );
  end

  lgc_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk     (clk),
    .rst     (rst),
    .v_in    (cv[NC]),
    .rdy_out (cr[NC]),
    .quo_in  (quo_a[NC]),
    .side_in (side_a[NC]),
    .result  (result)
  );

`ifndef SYNTHESIS
  // An open output lets the whole row advance, so the input must be open
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    result.ready |-> item.ready)
    else $error("input stalled while output is ready");

  // Last cell keeps its transaction while the blend stage is stalled
  a_last_hold: assert property (@(posedge clk) disable iff (rst)
    cv[NC] && !cr[NC] |=> cv[NC])
    else $error("divider row dropped a transaction under stall");

  // A result appears only after the last cell held one
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(cv[NC]))
    else $error("result appeared with no source transaction");

  // A forced full fraction yields exactly the end color
  a_full_frac: assert property (@(posedge clk) disable iff (rst)
    cv[NC] && cr[NC] && side_a[NC].one |=>
      result.pixel_color == $past(side_a[NC].colors.end_color))
    else $error("full fraction did not give the end color");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for line_gradient_color: directed and random pixels.
`timescale 1ns / 1ps

module tb;
  import lgc_pkg::*;

  localparam int  CB          = COORD_BITS_DEF;
  localparam int  FB          = FRAC_BITS_DEF;
  localparam longint ONE_FIX  = longint'(1) << FB;
  localparam int  PIPE_DEPTH  = FB + 3;
  localparam int  CYCLE_LIMIT = 200000;

  // One pixel request as it travels on the item channel
  typedef struct packed {
    logic signed [CB-1:0]    start_x;
    logic signed [CB-1:0]    start_y;
    logic signed [CB-1:0]    end_x;
    logic signed [CB-1:0]    end_y;
    logic signed [CB-1:0]    cur_x;
    logic signed [CB-1:0]    cur_y;
    logic [COLOR_BITS-1:0]   start_color;
    logic [COLOR_BITS-1:0]   end_color;
    logic [COLOR_BITS-1:0]   cur_color;
    logic [SPAN_BITS-1:0]    span_x;
    logic [SPAN_BITS-1:0]    span_y;
  } pixel_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lgc_item_if #(.COORD_BITS(CB)) item_ch ();
  lgc_result_if                  result_ch ();

  line_gradient_color #(
    .COORD_BITS(CB),
    .FRAC_BITS (FB)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch)
  );

  logic [COLOR_BITS-1:0] expected_colors[$];
  int unsigned           error_count = 0;
  int unsigned           cycle_count = 0;
  bit                    source_gaps = 1'b0;
  bit                    sink_stalls = 1'b0;
  int unsigned           hold_req    = 0;
  int unsigned           hold_left   = 0;
  int unsigned           stall_left  = 0;

  // Clock, 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Fraction along one axis, clamped to [0, ONE]
  function automatic logic [FB:0] axis_fraction(input logic signed [CB-1:0] s,
                                                input logic signed [CB-1:0] e,
                                                input logic signed [CB-1:0] c);
    longint num;
    longint den;
    longint an;
    longint ad;
    num = longint'(c) - longint'(s);
    den = longint'(e) - longint'(s);
    if (den == 0) return ONE_FIX[FB:0];
    if (num == 0 || ((num < 0) != (den < 0))) return '0;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    if (an >= ad) return ONE_FIX[FB:0];
    return (FB+1)'((an << FB) / ad);
  endfunction

  function automatic logic [CHAN_BITS-1:0] blend_chan(input logic [CHAN_BITS-1:0] a,
                                                      input logic [CHAN_BITS-1:0] b,
                                                      input logic [FB:0]          f);
    longint sum;
    sum = longint'(a) * (ONE_FIX - longint'(f)) + longint'(b) * longint'(f);
    return CHAN_BITS'(sum >> FB);
  endfunction

  function automatic logic [COLOR_BITS-1:0] predict_pixel(input pixel_req_t p);
    logic [FB:0]           frac;
    logic [COLOR_BITS-1:0] px;
    if (p.cur_color == p.end_color) return p.cur_color;
    if (p.span_x > p.span_y) frac = axis_fraction(p.start_x, p.end_x, p.cur_x);
    else                     frac = axis_fraction(p.start_y, p.end_y, p.cur_y);
    for (int ch = 0; ch < NUM_CHAN; ch++)
      px[ch*CHAN_BITS +: CHAN_BITS] = blend_chan(p.start_color[ch*CHAN_BITS +: CHAN_BITS],
                                                 p.end_color[ch*CHAN_BITS +: CHAN_BITS],
                                                 frac);
    return px;
  endfunction

  function automatic pixel_req_t mk_req(input int sx, input int sy, input int ex,
                                        input int ey, input int cx, input int cy,
                                        input logic [23:0] scol, input logic [23:0] ecol,
                                        input logic [23:0] ccol, input int spx,
                                        input int spy);
    pixel_req_t p;
    p.start_x = sx[CB-1:0];  p.start_y = sy[CB-1:0];
    p.end_x   = ex[CB-1:0];  p.end_y   = ey[CB-1:0];
    p.cur_x   = cx[CB-1:0];  p.cur_y   = cy[CB-1:0];
    p.start_color = scol;    p.end_color = ecol;  p.cur_color = ccol;
    p.span_x  = spx[SPAN_BITS-1:0];
    p.span_y  = spy[SPAN_BITS-1:0];
    return p;
  endfunction

  function automatic int coord_clip(input int v);
    if (v > 32767)  return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int abs_int(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // Drive one transaction on the item channel; record its expected color
  task automatic send_pixel(input pixel_req_t p);
    if (source_gaps && $urandom_range(0, 4) == 0) begin
      item_ch.valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    item_ch.valid       = 1'b1;
    item_ch.start_x     = p.start_x;
    item_ch.start_y     = p.start_y;
    item_ch.end_x       = p.end_x;
    item_ch.end_y       = p.end_y;
    item_ch.cur_x       = p.cur_x;
    item_ch.cur_y       = p.cur_y;
    item_ch.start_color = p.start_color;
    item_ch.end_color   = p.end_color;
    item_ch.cur_color   = p.cur_color;
    item_ch.span_x      = p.span_x;
    item_ch.span_y      = p.span_y;
    do @(posedge clk); while (!item_ch.ready);
    expected_colors.push_back(predict_pixel(p));
    @(negedge clk);
  endtask

  // A pixel on (or a little past) a consistent line with random colors
  task automatic send_line_pixel();
    int sx, sy, ex, ey, cx, cy, t;
    logic [23:0] ecol;
    sx = int'($urandom_range(0, 65535)) - 32768;
    sy = int'($urandom_range(0, 65535)) - 32768;
    if ($urandom_range(0, 1)) begin
      ex = coord_clip(sx + int'($urandom_range(0, 128)) - 64);
      ey = coord_clip(sy + int'($urandom_range(0, 128)) - 64);
    end else begin
      ex = int'($urandom_range(0, 65535)) - 32768;
      ey = int'($urandom_range(0, 65535)) - 32768;
    end
    t  = int'($urandom_range(0, 19)) - 2;
    cx = coord_clip(sx + int'((longint'(ex - sx) * t) / 16));
    cy = coord_clip(sy + int'((longint'(ey - sy) * t) / 16));
    ecol = 24'($urandom());
    send_pixel(mk_req(sx, sy, ex, ey, cx, cy, 24'($urandom()), ecol,
                      ($urandom_range(0, 9) == 0) ? ecol : 24'($urandom()),
                      abs_int(ex - sx), abs_int(ey - sy)));
  endtask

  // Every field random, with cur_color sometimes set to end_color and span_y to span_x
  task automatic send_noise_pixel();
    pixel_req_t p;
    logic [223:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
           $urandom()};
    p = raw[$bits(pixel_req_t)-1:0];
    if ($urandom_range(0, 7) == 0) p.cur_color = p.end_color;
    if ($urandom_range(0, 7) == 0) p.span_y = p.span_x;
    send_pixel(p);
  endtask

  // Result checker
  always @(posedge clk) begin
    logic [COLOR_BITS-1:0] exp_color;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_colors.size() == 0) begin
        $error("pixel_color: unexpected transaction, actual %06h", result_ch.pixel_color);
        error_count++;
      end else begin
        exp_color = expected_colors.pop_front();
        if (result_ch.pixel_color !== exp_color) begin
          $error("pixel_color: expected %06h, actual %06h", exp_color,
                 result_ch.pixel_color);
          error_count++;
        end
      end
    end
  end

  // Result receiver: random stall bursts, plus long holds on request
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready = 1'b0;
    end else if (hold_req != 0) begin
      hold_left = hold_req - 1;
      hold_req  = 0;
      result_ch.ready = 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      result_ch.ready = 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      result_ch.ready = 1'b0;
    end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 10);
      result_ch.ready = 1'b0;
    end else begin
      result_ch.ready = 1'b1;
    end
  end

  task automatic test_end_color_passthrough();
    send_pixel(mk_req(10, 20, 300, 40, 150, 30, 24'h000000, 24'hFFFFFF, 24'hFFFFFF,
                      290, 20));
    send_pixel(mk_req(-32768, 32767, 32767, -32768, 0, 0, 24'hFFFFFF, 24'h000000,
                      24'h000000, 65535, 65535));
    send_pixel(mk_req(0, 0, 0, 0, 0, 0, 24'h123456, 24'hA5C3E1, 24'hA5C3E1, 0, 0));
  endtask

  task automatic test_axis_select();
    // x major: midpoint on x, y axis would say end
    send_pixel(mk_req(0, 0, 100, 10, 50, 10, 24'h000000, 24'hFFFFFF, 24'h000001, 100, 10));
    // equal spans pick y: x would clamp to start
    send_pixel(mk_req(0, 0, 50, 50, -5, 25, 24'h00FF00, 24'hFF00FF, 24'h000000, 50, 50));
    send_pixel(mk_req(-100, 7, 200, -9, 20, 1, 24'hFF8040, 24'h0080C0, 24'h111111,
                      65535, 0));
    send_pixel(mk_req(3, -200, -4, 200, 0, 100, 24'h102030, 24'hF0E0D0, 24'h111111,
                      0, 65535));
  endtask

  task automatic test_zero_span();
    send_pixel(mk_req(1234, 0, 1234, 10, 999, 5, 24'h000000, 24'h80FF01, 24'h000000, 5, 2));
    send_pixel(mk_req(4, -32768, 9, -32768, 6, 100, 24'hFFFFFF, 24'h017F80, 24'h000000,
                      5, 5));
  endtask

  task automatic test_clamp();
    // before the start, beyond the end, exactly at the end, at the start
    send_pixel(mk_req(100, 0, 200, 0, 50, 0, 24'h204060, 24'hC0A080, 24'h000000, 100, 0));
    send_pixel(mk_req(0, -10, 0, 30, 0, 90, 24'h204060, 24'hC0A080, 24'h000000, 0, 40));
    send_pixel(mk_req(0, 0, 77, 0, 77, 0, 24'hFFFFFF, 24'h000000, 24'h000001, 77, 0));
    send_pixel(mk_req(-9, 0, 30, 0, -9, 0, 24'hFFFFFF, 24'h000000, 24'h000001, 39, 0));
    // line running in the negative direction
    send_pixel(mk_req(0, 300, 0, -300, 0, -100, 24'h0000FF, 24'hFF0000, 24'h000000, 0, 600));
    send_pixel(mk_req(0, 300, 0, -300, 0, 301, 24'h0000FF, 24'hFF0000, 24'h000000, 0, 600));
  endtask

  task automatic test_coord_extremes();
    send_pixel(mk_req(-32768, 0, 32767, 0, 32766, 0, 24'h000000, 24'hFFFFFF, 24'h7F7F7F,
                      65535, 0));
    send_pixel(mk_req(32767, 0, -32768, 0, -32767, 0, 24'h000000, 24'hFFFFFF, 24'h7F7F7F,
                      65535, 1));
    send_pixel(mk_req(0, -32768, 0, 32767, 0, -32767, 24'hFFFFFF, 24'h000000, 24'h000001,
                      0, 65535));
    send_pixel(mk_req(0, 32767, 0, -32768, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 24'h000000,
                      1, 65535));
    send_pixel(mk_req(-1, -1, 1, 1, 0, 0, 24'h0000FF, 24'hFFFF00, 24'hFFFFFE, 2, 2));
  endtask

  task automatic test_random_lines(input int count);
    repeat (count) begin
      if ($urandom_range(0, 5) != 0) send_line_pixel();
      else                           send_noise_pixel();
    end
  endtask

  // Receiver holds off long enough for the block to fill and stall its input
  task automatic test_backpressure();
    hold_req = 400;
    repeat (60) send_line_pixel();
  endtask

  initial begin
    item_ch.valid       = 1'b0;
    item_ch.start_x     = '0;
    item_ch.start_y     = '0;
    item_ch.end_x       = '0;
    item_ch.end_y       = '0;
    item_ch.cur_x       = '0;
    item_ch.cur_y       = '0;
    item_ch.start_color = '0;
    item_ch.end_color   = '0;
    item_ch.cur_color   = '0;
    item_ch.span_x      = '0;
    item_ch.span_y      = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_end_color_passthrough();
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
    test_axis_select();
    test_zero_span();
    test_clamp();
    test_coord_extremes();
    test_random_lines(700);
    test_backpressure();
    test_random_lines(150);

    // closing stretch at full rate on both sides
    source_gaps = 1'b0;
    sink_stalls = 1'b0;
    test_random_lines(120);
    item_ch.valid = 1'b0;

    while (expected_colors.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 8) @(posedge clk);

    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== line_gradient_color.f =====
design/lgc_pkg.sv
design/lgc_if.sv
design/lgc_front.sv
design/lgc_div_cell.sv
design/lgc_blend.sv
design/line_gradient_color.sv
tb/tb.sv
